/* sv/pfs_pkg.sv */
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants for the Phong fragment shading core.
// ----------------------------------------------------------------------------
`default_nettype none

package pfs_pkg;

    localparam int COORD_W        = 32;     // input coordinate width, Q16.16
    localparam int DIFF_W         = 34;     // exact difference width
    localparam int UNIT_W         = 18;     // unit component, [-1.0, 1.0] in Q16
    localparam int RED_W          = 17;
    localparam int GREEN_W        = 18;
    localparam int CFG_IDX_W      = 3;
    localparam int SHININESS_DEF  = 40;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef logic signed [DIFF_W-1:0] vec_comp_t;
    typedef logic signed [UNIT_W-1:0] unit_t;

    // one fragment as it travels from front to back
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] nrm;   // normal, sign extended
        logic [2:0][DIFF_W-1:0] ld;    // light minus fragment
        logic [2:0][DIFF_W-1:0] vd;    // camera minus fragment
    } frag_t;

    // queue status seen by the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIGHT_X  = 3'd0,
        REG_LIGHT_Y  = 3'd1,
        REG_LIGHT_Z  = 3'd2,
        REG_CAMERA_X = 3'd3,
        REG_CAMERA_Y = 3'd4,
        REG_CAMERA_Z = 3'd5
    } cfg_reg_e;

endpackage

`default_nettype wire

/* sv/pfs_front.sv */
// ----------------------------------------------------------------------------
// pfs_front
// Holds light and camera positions, takes fragment beats and pushes the
// normal and the direction differences into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] frag_pos_x,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] frag_pos_y,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] frag_pos_z,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] normal_x,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] normal_y,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] normal_z,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [pfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pfs_pkg::COORD_W-1:0]       cfg_data,
    input  wire pfs_pkg::q_status_t                q_stat,
    output logic                                   push,
    output pfs_pkg::frag_t                         push_data
);

    logic signed [pfs_pkg::COORD_W-1:0] light_reg  [3];
    logic signed [pfs_pkg::COORD_W-1:0] camera_reg [3];
    logic signed [pfs_pkg::COORD_W-1:0] pos        [3];

    assign cfg_ready = 1'b1;
    assign busy      = q_stat.full;
    assign push      = start & ~q_stat.full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                light_reg[i]  <= '0;
                camera_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (pfs_pkg::cfg_reg_e'(cfg_index))
                pfs_pkg::REG_LIGHT_X:  light_reg[0]  <= cfg_data;
                pfs_pkg::REG_LIGHT_Y:  light_reg[1]  <= cfg_data;
                pfs_pkg::REG_LIGHT_Z:  light_reg[2]  <= cfg_data;
                pfs_pkg::REG_CAMERA_X: camera_reg[0] <= cfg_data;
                pfs_pkg::REG_CAMERA_Y: camera_reg[1] <= cfg_data;
                pfs_pkg::REG_CAMERA_Z: camera_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // exact 34-bit directions
    always_comb
    begin
        pos[0] = frag_pos_x;
        pos[1] = frag_pos_y;
        pos[2] = frag_pos_z;
        push_data.nrm[0] = pfs_pkg::vec_comp_t'(normal_x);
        push_data.nrm[1] = pfs_pkg::vec_comp_t'(normal_y);
        push_data.nrm[2] = pfs_pkg::vec_comp_t'(normal_z);
        for (int i = 0; i < 3; i++)
        begin
            push_data.ld[i] = pfs_pkg::vec_comp_t'(light_reg[i])
                            - pfs_pkg::vec_comp_t'(pos[i]);
            push_data.vd[i] = pfs_pkg::vec_comp_t'(camera_reg[i])
                            - pfs_pkg::vec_comp_t'(pos[i]);
        end
    end

endmodule

`default_nettype wire

/* sv/pfs_queue.sv */
// ----------------------------------------------------------------------------
// pfs_queue
// Short fragment queue between front and back; drains one beat a cycle
// into a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_queue #(
    parameter int DEPTH = pfs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pfs_pkg::frag_t push_data,
    output pfs_pkg::q_status_t  q_stat,
    output logic                rd_valid,
    output pfs_pkg::frag_t      rd_data
);

    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfs_pkg::frag_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             rd_valid_reg;
    pfs_pkg::frag_t   rd_data_reg;
    logic             pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop          = ~q_stat.empty;
    assign rd_valid     = rd_valid_reg;
    assign rd_data      = rd_data_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
        if (pop)
            rd_data_reg <= mem[rd_ptr_reg];
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= pop;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* sv/pfs_norm.sv */
// ----------------------------------------------------------------------------
// pfs_norm
// Pipelined vector normalizer: magnitude scaling, squares, a bit-per-stage
// square root and a bit-per-stage divider for each component.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_norm (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    input  wire logic [2:0][pfs_pkg::DIFF_W-1:0]      in_vec,
    output logic                                      out_valid,
    output logic [2:0][pfs_pkg::UNIT_W-1:0]           out_unit
);

    localparam int MW        = pfs_pkg::DIFF_W;  // raw magnitude width
    localparam int SW        = 30;               // scaled magnitude width
    localparam int SQ_STAGES = 31;               // root bits
    localparam int DV_STAGES = 17;               // quotient bits

    // stage A: magnitudes and signs
    logic            a_vld_reg;
    logic [2:0][MW-1:0] a_mag_reg;
    logic [2:0]      a_sign_reg;
    logic [MW-1:0]   a_or_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_sign_reg[i] <= in_vec[i][MW-1];
            a_mag_reg[i]  <= in_vec[i][MW-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        end
        a_or_reg <= (in_vec[0][MW-1] ? (~in_vec[0] + 1'b1) : in_vec[0])
                  | (in_vec[1][MW-1] ? (~in_vec[1] + 1'b1) : in_vec[1])
                  | (in_vec[2][MW-1] ? (~in_vec[2] + 1'b1) : in_vec[2]);
    end

    // stage B: leading one of the largest magnitude
    logic            b_vld_reg;
    logic [2:0][MW-1:0] b_mag_reg;
    logic [2:0]      b_sign_reg;
    logic [5:0]      b_pos_reg;
    logic            b_zero_reg;
    logic [5:0]      lead_pos;

    always_comb
    begin
        lead_pos = '0;
        for (int j = 0; j < MW; j++)
        begin
            if (a_or_reg[j])
                lead_pos = 6'(j);
        end
    end

    always_ff @(posedge clk)
    begin
        b_mag_reg  <= a_mag_reg;
        b_sign_reg <= a_sign_reg;
        b_pos_reg  <= lead_pos;
        b_zero_reg <= (a_or_reg == '0);
    end

    // stage C: scale so the largest lies in [2^29, 2^30)
    logic            c_vld_reg;
    logic [2:0][SW-1:0] c_mag_reg;
    logic [2:0]      c_sign_reg;
    logic            c_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (b_pos_reg >= 6'd29)
                c_mag_reg[i] <= SW'(b_mag_reg[i] >> (b_pos_reg - 6'd29));
            else
                c_mag_reg[i] <= SW'(b_mag_reg[i] << (6'd29 - b_pos_reg));
        end
        c_sign_reg <= b_sign_reg;
        c_zero_reg <= b_zero_reg;
    end

    // stage D: squares
    logic            d_vld_reg;
    logic [2:0][2*SW-1:0] d_sq_reg;
    logic [2:0][SW-1:0]   d_mag_reg;
    logic [2:0]      d_sign_reg;
    logic            d_zero_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            d_sq_reg[i] <= c_mag_reg[i] * c_mag_reg[i];
        d_mag_reg  <= c_mag_reg;
        d_sign_reg <= c_sign_reg;
        d_zero_reg <= c_zero_reg;
    end

    // square root pipeline, entry 0 holds the sum of squares
    logic [63:0]            sq_rem_reg  [0:SQ_STAGES];
    logic [SQ_STAGES-1:0]   sq_res_reg  [0:SQ_STAGES];
    logic [2:0][SW-1:0]     sq_mag_reg  [0:SQ_STAGES];
    logic [2:0]             sq_sign_reg [0:SQ_STAGES];
    logic                   sq_zero_reg [0:SQ_STAGES];
    logic                   sq_vld_reg  [0:SQ_STAGES];

    always_ff @(posedge clk)
    begin
        sq_rem_reg[0]  <= 64'(d_sq_reg[0]) + 64'(d_sq_reg[1]) + 64'(d_sq_reg[2]);
        sq_res_reg[0]  <= '0;
        sq_mag_reg[0]  <= d_mag_reg;
        sq_sign_reg[0] <= d_sign_reg;
        sq_zero_reg[0] <= d_zero_reg;
    end

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_sqrt
        localparam int B = SQ_STAGES - 1 - k;
        logic [63:0] delta;

        assign delta = (64'(sq_res_reg[k]) << (B + 1)) + (64'd1 << (2 * B));

        always_ff @(posedge clk)
        begin
            if (sq_rem_reg[k] >= delta)
            begin
                sq_rem_reg[k+1] <= sq_rem_reg[k] - delta;
                sq_res_reg[k+1] <= sq_res_reg[k] | (SQ_STAGES'(1) << B);
            end
            else
            begin
                sq_rem_reg[k+1] <= sq_rem_reg[k];
                sq_res_reg[k+1] <= sq_res_reg[k];
            end
            sq_mag_reg[k+1]  <= sq_mag_reg[k];
            sq_sign_reg[k+1] <= sq_sign_reg[k];
            sq_zero_reg[k+1] <= sq_zero_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[k+1] <= 1'b0;
            else
                sq_vld_reg[k+1] <= sq_vld_reg[k];
        end
    end

    // divider pipeline: component * 2^16 / length, one quotient bit a stage
    logic [2:0][47:0]           dv_rem_reg  [1:DV_STAGES];
    logic [2:0][DV_STAGES-1:0]  dv_q_reg    [1:DV_STAGES];
    logic [SQ_STAGES-1:0]       dv_len_reg  [1:DV_STAGES];
    logic [2:0]                 dv_sign_reg [1:DV_STAGES];
    logic                       dv_zero_reg [1:DV_STAGES];
    logic                       dv_vld_reg  [1:DV_STAGES];

    for (genvar k = 0; k < DV_STAGES; k++)
    begin : g_div
        localparam int B = DV_STAGES - 1 - k;
        logic [2:0][47:0]          rem_in;
        logic [2:0][DV_STAGES-1:0] q_in;
        logic [SQ_STAGES-1:0]      len_in;
        logic [2:0]                sign_in;
        logic                      zero_in;
        logic                      vld_in;
        logic [47:0]               den;

        if (k == 0)
        begin : g_src
            for (genvar i = 0; i < 3; i++)
            begin : g_comp
                assign rem_in[i] = {2'b00, sq_mag_reg[SQ_STAGES][i], 16'h0000};
            end
            assign q_in    = '0;
            assign len_in  = sq_res_reg[SQ_STAGES];
            assign sign_in = sq_sign_reg[SQ_STAGES];
            assign zero_in = sq_zero_reg[SQ_STAGES];
            assign vld_in  = sq_vld_reg[SQ_STAGES];
        end
        else
        begin : g_chain
            assign rem_in  = dv_rem_reg[k];
            assign q_in    = dv_q_reg[k];
            assign len_in  = dv_len_reg[k];
            assign sign_in = dv_sign_reg[k];
            assign zero_in = dv_zero_reg[k];
            assign vld_in  = dv_vld_reg[k];
        end

        assign den = 48'(len_in) << B;

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (rem_in[i] >= den)
                begin
                    dv_rem_reg[k+1][i] <= rem_in[i] - den;
                    dv_q_reg[k+1][i]   <= q_in[i] | (DV_STAGES'(1) << B);
                end
                else
                begin
                    dv_rem_reg[k+1][i] <= rem_in[i];
                    dv_q_reg[k+1][i]   <= q_in[i];
                end
            end
            dv_len_reg[k+1]  <= len_in;
            dv_sign_reg[k+1] <= sign_in;
            dv_zero_reg[k+1] <= zero_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[k+1] <= 1'b0;
            else
                dv_vld_reg[k+1] <= vld_in;
        end
    end

    // output: apply sign, zero vector gives zero
    logic                        o_vld_reg;
    logic [2:0][pfs_pkg::UNIT_W-1:0] o_unit_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_zero_reg[DV_STAGES])
                o_unit_reg[i] <= '0;
            else if (dv_sign_reg[DV_STAGES][i])
                o_unit_reg[i] <= ~{1'b0, dv_q_reg[DV_STAGES][i]} + 1'b1;
            else
                o_unit_reg[i] <= {1'b0, dv_q_reg[DV_STAGES][i]};
        end
    end

    // front stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg     <= 1'b0;
            b_vld_reg     <= 1'b0;
            c_vld_reg     <= 1'b0;
            d_vld_reg     <= 1'b0;
            sq_vld_reg[0] <= 1'b0;
            o_vld_reg     <= 1'b0;
        end
        else
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            sq_vld_reg[0] <= d_vld_reg;
            o_vld_reg     <= dv_vld_reg[DV_STAGES];
        end
    end

    assign out_valid = o_vld_reg;
    assign out_unit  = o_unit_reg;

endmodule

`default_nettype wire

/* sv/pfs_back.sv */
// ----------------------------------------------------------------------------
// pfs_back
// Normalizes the three vectors, forms diffuse, reflection and specular
// dot products and raises the specular term to the shininess power.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_back #(
    parameter int SHININESS = pfs_pkg::SHININESS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire pfs_pkg::frag_t                 in_data,
    output logic                                done,
    output logic [pfs_pkg::RED_W-1:0]           color_red,
    output logic [pfs_pkg::GREEN_W-1:0]         color_green,
    output logic [pfs_pkg::RED_W-1:0]           color_blue
);

    localparam int PW = SHININESS - 1;

    logic                                n_vld, l_vld, v_vld;
    logic [2:0][pfs_pkg::UNIT_W-1:0]     n_unit, l_unit, v_unit;

    pfs_norm u_norm_n (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_vec(in_data.nrm),
        .out_valid(n_vld), .out_unit(n_unit)
    );

    pfs_norm u_norm_l (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_vec(in_data.ld),
        .out_valid(l_vld), .out_unit(l_unit)
    );

    pfs_norm u_norm_v (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_vec(in_data.vd),
        .out_valid(v_vld), .out_unit(v_unit)
    );

    // stage 1: N*L products
    logic signed [35:0] b1_nl_reg [3];
    pfs_pkg::unit_t     b1_n_reg [3], b1_l_reg [3], b1_v_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            b1_nl_reg[i] <= $signed(n_unit[i]) * $signed(l_unit[i]);
            b1_n_reg[i]  <= n_unit[i];
            b1_l_reg[i]  <= l_unit[i];
            b1_v_reg[i]  <= v_unit[i];
        end
    end

    // stage 2: N.L, diffuse and the reflect scale (dot of N with -L)
    logic signed [37:0] nl_sum;
    logic signed [37:0] nl_trunc;
    logic [17:0]        b2_diff_reg;
    logic signed [18:0] b2_nd_reg;
    pfs_pkg::unit_t     b2_n_reg [3], b2_l_reg [3], b2_v_reg [3];

    always_comb
    begin
        nl_sum   = 38'(b1_nl_reg[0]) + 38'(b1_nl_reg[1]) + 38'(b1_nl_reg[2]);
        nl_trunc = (nl_sum + (nl_sum[37] ? 38'sd65535 : 38'sd0)) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        b2_diff_reg <= nl_sum[37] ? 18'd0 : nl_trunc[17:0];
        b2_nd_reg   <= -nl_trunc[18:0];
        b2_n_reg    <= b1_n_reg;
        b2_l_reg    <= b1_l_reg;
        b2_v_reg    <= b1_v_reg;
    end

    // stage 3: nd * N
    logic signed [36:0] b3_pp_reg [3];
    pfs_pkg::unit_t     b3_l_reg [3], b3_v_reg [3];
    logic [17:0]        b3_diff_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            b3_pp_reg[i] <= b2_nd_reg * b2_n_reg[i];
        b3_l_reg    <= b2_l_reg;
        b3_v_reg    <= b2_v_reg;
        b3_diff_reg <= b2_diff_reg;
    end

    // stage 4: R = -L - 2*nd*N / 2^16
    logic signed [37:0] twice [3];
    logic signed [37:0] twice_q [3];
    logic signed [21:0] b4_r_reg [3];
    pfs_pkg::unit_t     b4_v_reg [3];
    logic [17:0]        b4_diff_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            twice[i]   = {b3_pp_reg[i], 1'b0};
            twice_q[i] = (twice[i] + (twice[i][37] ? 38'sd65535 : 38'sd0)) >>> 16;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            b4_r_reg[i] <= -22'(b3_l_reg[i]) - twice_q[i][21:0];
        b4_v_reg    <= b3_v_reg;
        b4_diff_reg <= b3_diff_reg;
    end

    // stage 5: V*R products
    logic signed [39:0] b5_vr_reg [3];
    logic [17:0]        b5_diff_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            b5_vr_reg[i] <= b4_v_reg[i] * b4_r_reg[i];
        b5_diff_reg <= b4_diff_reg;
    end

    // stage 6: V.R clamped to [0, 1.0] starts the power chain
    logic signed [41:0] vr_sum;
    logic signed [41:0] vr_shift;
    logic [16:0]        spec_base;

    always_comb
    begin
        vr_sum   = 42'(b5_vr_reg[0]) + 42'(b5_vr_reg[1]) + 42'(b5_vr_reg[2]);
        vr_shift = vr_sum >>> 16;
        if (vr_sum[41])
            spec_base = '0;
        else if (vr_shift > 42'sd65536)
            spec_base = 17'd65536;
        else
            spec_base = vr_shift[16:0];
    end

    logic [16:0] pw_acc_reg  [0:PW];
    logic [16:0] pw_s_reg    [0:PW];
    logic [17:0] pw_diff_reg [0:PW];
    logic        pw_vld_reg  [0:PW];

    always_ff @(posedge clk)
    begin
        pw_acc_reg[0]  <= spec_base;
        pw_s_reg[0]    <= spec_base;
        pw_diff_reg[0] <= b5_diff_reg;
    end

    // power chain: one multiply per stage
    for (genvar k = 0; k < PW; k++)
    begin : g_pow
        logic [33:0] prod;

        assign prod = pw_acc_reg[k] * pw_s_reg[k];

        always_ff @(posedge clk)
        begin
            pw_acc_reg[k+1]  <= prod[32:16];
            pw_s_reg[k+1]    <= pw_s_reg[k];
            pw_diff_reg[k+1] <= pw_diff_reg[k];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                pw_vld_reg[k+1] <= 1'b0;
            else
                pw_vld_reg[k+1] <= pw_vld_reg[k];
        end
    end

    // output register
    logic                        done_reg;
    logic [pfs_pkg::RED_W-1:0]   red_reg;
    logic [pfs_pkg::GREEN_W-1:0] green_reg;

    always_ff @(posedge clk)
    begin
        red_reg   <= pw_acc_reg[PW];
        green_reg <= pw_diff_reg[PW] + 18'(pw_acc_reg[PW]);
    end

    // stage valids
    logic b1_vld_reg, b2_vld_reg, b3_vld_reg, b4_vld_reg, b5_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg    <= 1'b0;
            b2_vld_reg    <= 1'b0;
            b3_vld_reg    <= 1'b0;
            b4_vld_reg    <= 1'b0;
            b5_vld_reg    <= 1'b0;
            pw_vld_reg[0] <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            b1_vld_reg    <= n_vld & l_vld & v_vld;
            b2_vld_reg    <= b1_vld_reg;
            b3_vld_reg    <= b2_vld_reg;
            b4_vld_reg    <= b3_vld_reg;
            b5_vld_reg    <= b4_vld_reg;
            pw_vld_reg[0] <= b5_vld_reg;
            done_reg      <= pw_vld_reg[PW];
        end
    end

    assign done        = done_reg;
    assign color_red   = red_reg;
    assign color_green = green_reg;
    assign color_blue  = red_reg;

endmodule

`default_nettype wire

/* sv/phong_fragment_shading_core.sv */
// ----------------------------------------------------------------------------
// phong_fragment_shading_core
// Per-fragment Phong shading in Q16.16: front takes fragments, a short
// queue decouples it from the fully pipelined shading back end.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     start / busy         frag_pos_x..z, normal_x..z
//  result    done (one cycle)     color_red, color_green, color_blue
//  config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One fragment per clock, sustained, through the bit-per-stage square root
//  and divider of the normalizers and the one-multiply-per-stage power chain.
//  rst_n clears all valids and sets light and camera positions to zero.
//  The receiver cannot stall; the back end never stops, so busy only rises
//  if the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module phong_fragment_shading_core #(
    parameter int SHININESS   = pfs_pkg::SHININESS_DEF,
    parameter int QUEUE_DEPTH = pfs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] frag_pos_x,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] frag_pos_y,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] frag_pos_z,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] normal_x,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] normal_y,
    input  wire logic signed [pfs_pkg::COORD_W-1:0] normal_z,
    output logic                                    done,
    output logic [pfs_pkg::RED_W-1:0]               color_red,
    output logic [pfs_pkg::GREEN_W-1:0]             color_green,
    output logic [pfs_pkg::RED_W-1:0]               color_blue,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pfs_pkg::COORD_W-1:0]        cfg_data
);

    pfs_pkg::q_status_t q_stat;
    pfs_pkg::frag_t     push_data, rd_data;
    logic               push, rd_valid;

    pfs_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .frag_pos_x(frag_pos_x), .frag_pos_y(frag_pos_y), .frag_pos_z(frag_pos_z),
        .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_stat(q_stat), .push(push), .push_data(push_data)
    );

    pfs_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data),
        .q_stat(q_stat), .rd_valid(rd_valid), .rd_data(rd_data)
    );

    pfs_back #(.SHININESS(SHININESS)) u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(rd_valid), .in_data(rd_data),
        .done(done), .color_red(color_red), .color_green(color_green),
        .color_blue(color_blue)
    );

endmodule

`default_nettype wire

/* sv/pfs_checker.sv */
// ----------------------------------------------------------------------------
// pfs_checker
// Port-level checks on shading results, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module pfs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [pfs_pkg::RED_W-1:0]     color_red,
    input wire logic [pfs_pkg::GREEN_W-1:0]   color_green,
    input wire logic [pfs_pkg::RED_W-1:0]     color_blue,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready
);

    // white specular: red and blue always agree
    a_red_blue: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> color_red == color_blue)
        else $error("red and blue differ");

    // specular saturates at 1.0
    a_spec_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> color_red <= 17'd65536)
        else $error("specular above 1.0");

    // green carries specular plus a non-negative diffuse
    a_green_ge: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> color_green >= 18'(color_red))
        else $error("green below specular");

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !done)
        else $error("result beat during reset");

    // back end drains every cycle, so fragment and config beats go straight in
    a_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (start || cfg_valid) |-> (!busy && cfg_ready))
        else $error("beat held off");

endmodule

bind phong_fragment_shading_core pfs_checker u_pfs_checker (.*);

`default_nettype wire
